[src/ucd_pkg.sv]
// ============================================================================
// ucd_pkg
// Shared types, constants and tables for the Unix time to UTC date converter.
// ============================================================================
package ucd_pkg;

    localparam int NUM_STAGES = 15;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } pipe_ctl_t;

    localparam int TIME_W   = 32;
    localparam int DAYS_W   = 16;
    localparam int SOD_W    = 17;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;

    // Day of year at which each March-based month starts: (153 * mp + 2) / 5.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

[src/unix_time_to_utc_datetime_unit.sv]
// ============================================================================
// unix_time_to_utc_datetime_unit
// Converts a Unix seconds count to UTC year, month, day, hour and minute.
// ============================================================================
// Throughput: one item per cycle while the output is not stalled, set by the 15
// register stages of reciprocal multiplies and corrections, each taking a new
// item every cycle unless held by back-pressure.
// A stalled output fills empty stages first, so input transfers continue.
// Reset clears all stage valid bits asynchronously; data registers are not reset.
module unix_time_to_utc_datetime_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             unix_time_valid,
    output logic                             unix_time_ready,
    input  logic [ucd_pkg::TIME_W-1:0]       unix_time,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic                             valid_res,
    output logic [ucd_pkg::YEAR_W-1:0]       year,
    output logic [ucd_pkg::MONTH_W-1:0]      month,
    output logic [ucd_pkg::DAY_W-1:0]        day,
    output logic [ucd_pkg::HOUR_W-1:0]       hour,
    output logic [ucd_pkg::MINUTE_W-1:0]     minute
);
    import ucd_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] zero_reg;
    pipe_ctl_t             ctl;

    logic [DAYS_W-1:0]     days;
    logic [SOD_W-1:0]      sod;
    logic [YEAR_W-1:0]     date_year;
    logic [MONTH_W-1:0]    date_month;
    logic [DAY_W-1:0]      date_day;
    logic [HOUR_W-1:0]     time_hour;
    logic [MINUTE_W-1:0]   time_minute;
    logic                  is_zero;

    always_comb
    begin
        ctl.en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || result_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            ctl.en[i] = !vld_reg[i] || ctl.en[i+1];
        end
    end

    assign unix_time_ready = ctl.en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ctl.en[0])
            begin
                vld_reg[0] <= unix_time_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (ctl.en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            zero_reg[0] <= (unix_time == '0);
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (ctl.en[i])
            begin
                zero_reg[i] <= zero_reg[i-1];
            end
        end
    end

    ucd_split u_split (
        .clk       (clk),
        .ctl       (ctl),
        .unix_time (unix_time),
        .days      (days),
        .sod       (sod)
    );

    ucd_date u_date (
        .clk   (clk),
        .ctl   (ctl),
        .days  (days),
        .year  (date_year),
        .month (date_month),
        .day   (date_day)
    );

    ucd_clock u_clock (
        .clk    (clk),
        .ctl    (ctl),
        .sod    (sod),
        .hour   (time_hour),
        .minute (time_minute)
    );

    // A zero timestamp is reported as not converted with all fields cleared.
    assign is_zero      = zero_reg[NUM_STAGES-1];
    assign result_valid = vld_reg[NUM_STAGES-1];
    assign valid_res    = !is_zero;
    assign year         = is_zero ? '0 : date_year;
    assign month        = is_zero ? '0 : date_month;
    assign day          = is_zero ? '0 : date_day;
    assign hour         = is_zero ? '0 : time_hour;
    assign minute       = is_zero ? '0 : time_minute;

`ifndef NO_ASSERTIONS
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && valid_res |-> month >= 4'd1 && month <= 4'd12
                                   && day >= 5'd1 && day <= 5'd31)
        else $error("Converted date has a month or day out of range.");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && valid_res |-> year >= 12'd1970 && year <= 12'd2106)
        else $error("Converted year is out of range.");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> hour < 5'd24 && minute < 6'd60)
        else $error("Hour or minute is out of range.");

    a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !valid_res |-> year == '0 && month == '0 && day == '0)
        else $error("Unconverted result carries a nonzero date.");

    a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> unix_time_ready)
        else $error("Input is stalled although the first stage is empty.");
`endif

endmodule

[src/ucd_split.sv]
// ============================================================================
// ucd_split
// Splits the seconds count into whole days and seconds of the day.
// ============================================================================
module ucd_split (
    input  logic                             clk,
    input  ucd_pkg::pipe_ctl_t               ctl,
    input  logic [ucd_pkg::TIME_W-1:0]       unix_time,
    output logic [ucd_pkg::DAYS_W-1:0]       days,
    output logic [ucd_pkg::SOD_W-1:0]        sod
);
    import ucd_pkg::*;

    // Division by 86400 is a shift by 7 and a division by 675 through
    // a truncated reciprocal followed by one correction step.
    localparam logic [25:0] DAY_RECIP = 26'd50903316;

    logic [50:0] prod0_reg;
    logic [24:0] num0_reg;
    logic [6:0]  low0_reg;
    logic [15:0] quot1_reg;
    logic [10:0] rem1_reg;
    logic [6:0]  low1_reg;
    logic [15:0] days2_reg;
    logic [16:0] sod2_reg;

    logic [15:0] quot_est;
    logic [24:0] rem_full;

    assign quot_est = prod0_reg[50:35];
    assign rem_full = num0_reg - ({9'd0, quot_est} * 25'd675);

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            prod0_reg <= {26'd0, unix_time[31:7]} * {25'd0, DAY_RECIP};
            num0_reg  <= unix_time[31:7];
            low0_reg  <= unix_time[6:0];
        end
        if (ctl.en[1])
        begin
            quot1_reg <= quot_est;
            rem1_reg  <= rem_full[10:0];
            low1_reg  <= low0_reg;
        end
        if (ctl.en[2])
        begin
            if (rem1_reg >= 11'd675)
            begin
                days2_reg <= quot1_reg + 16'd1;
                sod2_reg  <= {rem1_reg[9:0] - 10'd675, low1_reg};
            end
            else
            begin
                days2_reg <= quot1_reg;
                sod2_reg  <= {rem1_reg[9:0], low1_reg};
            end
        end
    end

    assign days = days2_reg;
    assign sod  = sod2_reg;

endmodule

[src/ucd_clock.sv]
// ============================================================================
// ucd_clock
// Derives hour and minute from the seconds of the day.
// ============================================================================
module ucd_clock (
    input  logic                             clk,
    input  ucd_pkg::pipe_ctl_t               ctl,
    input  logic [ucd_pkg::SOD_W-1:0]        sod,
    output logic [ucd_pkg::HOUR_W-1:0]       hour,
    output logic [ucd_pkg::MINUTE_W-1:0]     minute
);
    import ucd_pkg::*;

    localparam int DELAY = 6;

    logic [14:0] x3_reg;
    logic [26:0] prod3_reg;
    logic [10:0] quot4_reg;
    logic [4:0]  rem4_reg;
    logic [10:0] mins5_reg;
    logic [16:0] prod6_reg;
    logic [10:0] mins6_reg;
    logic [4:0]  hour7_reg;
    logic [6:0]  rem7_reg;
    logic [4:0]  hour_line_reg   [DELAY+1];
    logic [5:0]  minute_line_reg [DELAY+1];

    logic [10:0] quot_est;
    logic [14:0] rem_full;
    logic [4:0]  hour_est;
    logic [10:0] min_rem_full;

    assign quot_est     = prod3_reg[25:15];
    assign rem_full     = x3_reg - ({4'd0, quot_est} * 15'd15);
    assign hour_est     = prod6_reg[15:11];
    assign min_rem_full = mins6_reg - ({6'd0, hour_est} * 11'd60);

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            x3_reg    <= sod[16:2];
            prod3_reg <= {12'd0, sod[16:2]} * 27'd2184;
        end
        if (ctl.en[4])
        begin
            quot4_reg <= quot_est;
            rem4_reg  <= rem_full[4:0];
        end
        if (ctl.en[5])
        begin
            mins5_reg <= (rem4_reg >= 5'd15) ? quot4_reg + 11'd1 : quot4_reg;
        end
        if (ctl.en[6])
        begin
            prod6_reg <= {6'd0, mins5_reg} * 17'd34;
            mins6_reg <= mins5_reg;
        end
        if (ctl.en[7])
        begin
            hour7_reg <= hour_est;
            rem7_reg  <= min_rem_full[6:0];
        end
        if (ctl.en[8])
        begin
            if (rem7_reg >= 7'd60)
            begin
                hour_line_reg[0]   <= hour7_reg + 5'd1;
                minute_line_reg[0] <= rem7_reg[5:0] - 6'd60;
            end
            else
            begin
                hour_line_reg[0]   <= hour7_reg;
                minute_line_reg[0] <= rem7_reg[5:0];
            end
        end
        for (int i = 1; i <= DELAY; i++)
        begin
            if (ctl.en[8+i])
            begin
                hour_line_reg[i]   <= hour_line_reg[i-1];
                minute_line_reg[i] <= minute_line_reg[i-1];
            end
        end
    end

    assign hour   = hour_line_reg[DELAY];
    assign minute = minute_line_reg[DELAY];

endmodule

[src/ucd_date.sv]
// ============================================================================
// ucd_date
// Converts a day count to year, month and day with 400-year eras.
// ============================================================================
module ucd_date (
    input  logic                             clk,
    input  ucd_pkg::pipe_ctl_t               ctl,
    input  logic [ucd_pkg::DAYS_W-1:0]       days,
    output logic [ucd_pkg::YEAR_W-1:0]       year,
    output logic [ucd_pkg::MONTH_W-1:0]      month,
    output logic [ucd_pkg::DAY_W-1:0]        day
);
    import ucd_pkg::*;

    localparam logic [19:0] DAY_SHIFT  = 20'd719468;
    localparam logic [19:0] ERA5_START = 20'd730485;
    localparam logic [19:0] ERA4_START = 20'd584388;

    // Shifted day numbers of this input range always fall into era 4 or 5.
    logic        era_reg [3:13];
    logic [17:0] doe_reg [3:9];

    logic [25:0] prod4_reg;
    logic [2:0]  cent4_reg;
    logic        last4_reg;
    logic [6:0]  quot5_reg;
    logic [11:0] rem5_reg;
    logic [2:0]  cent5_reg;
    logic        last5_reg;
    logic [17:0] w6_reg;
    logic [17:0] w7_reg;
    logic [27:0] prod7_reg;
    logic [8:0]  quot8_reg;
    logic [9:0]  rem8_reg;
    logic [8:0]  yoe_reg [9:13];
    logic [8:0]  doy_reg [10:13];
    logic [10:0] n11_reg;
    logic [14:0] prod11_reg;
    logic [3:0]  quot12_reg;
    logic [8:0]  rem12_reg;
    logic [3:0]  mp13_reg;
    logic [11:0] year14_reg;
    logic [3:0]  month14_reg;
    logic [4:0]  day14_reg;

    logic [19:0] z3;
    logic        era5;
    logic [19:0] doe_full;
    logic [6:0]  q1460_est;
    logic [17:0] r1460_full;
    logic [6:0]  q1460;
    logic [17:0] w_next;
    logic [8:0]  yoe_est;
    logic [17:0] r365_full;
    logic [1:0]  yoe_cent;
    logic [17:0] doy_full;
    logic [10:0] n_next;
    logic [3:0]  mp_est;
    logic [10:0] r153_full;
    logic [3:0]  mon;
    logic [8:0]  day_full;
    logic [11:0] era_year;

    always_comb
    begin
        z3       = {4'd0, days} + DAY_SHIFT;
        era5     = (z3 >= ERA5_START);
        doe_full = z3 - (era5 ? ERA5_START : ERA4_START);

        q1460_est  = prod4_reg[24:18];
        r1460_full = doe_reg[4] - ({11'd0, q1460_est} * 18'd1460);

        q1460  = (rem5_reg >= 12'd1460) ? quot5_reg + 7'd1 : quot5_reg;
        w_next = doe_reg[5] - {11'd0, q1460} + {15'd0, cent5_reg} - {17'd0, last5_reg};

        yoe_est   = prod7_reg[26:18];
        r365_full = w7_reg - ({9'd0, yoe_est} * 18'd365);

        yoe_cent = 2'(yoe_reg[9] >= 9'd100) + 2'(yoe_reg[9] >= 9'd200)
                 + 2'(yoe_reg[9] >= 9'd300);
        doy_full = doe_reg[9] - (({9'd0, yoe_reg[9]} * 18'd365)
                 + {11'd0, yoe_reg[9][8:2]} - {16'd0, yoe_cent});

        n_next = ({2'd0, doy_reg[10]} * 11'd5) + 11'd2;

        mp_est    = prod11_reg[14:11];
        r153_full = n11_reg - ({7'd0, mp_est} * 11'd153);

        mon      = (mp13_reg < 4'd10) ? mp13_reg + 4'd3 : mp13_reg - 4'd9;
        day_full = doy_reg[13] - month_start(mp13_reg) + 9'd1;
        era_year = era_reg[13] ? 12'd2000 : 12'd1600;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            era_reg[3] <= era5;
            doe_reg[3] <= doe_full[17:0];
        end
        for (int i = 4; i <= 13; i++)
        begin
            if (ctl.en[i])
            begin
                era_reg[i] <= era_reg[i-1];
            end
        end
        for (int i = 4; i <= 9; i++)
        begin
            if (ctl.en[i])
            begin
                doe_reg[i] <= doe_reg[i-1];
            end
        end
        if (ctl.en[4])
        begin
            prod4_reg <= {8'd0, doe_reg[3]} * 26'd179;
            cent4_reg <= 3'(doe_reg[3] >= 18'd36524) + 3'(doe_reg[3] >= 18'd73048)
                       + 3'(doe_reg[3] >= 18'd109572) + 3'(doe_reg[3] >= 18'd146096);
            last4_reg <= (doe_reg[3] == 18'd146096);
        end
        if (ctl.en[5])
        begin
            quot5_reg <= q1460_est;
            rem5_reg  <= r1460_full[11:0];
            cent5_reg <= cent4_reg;
            last5_reg <= last4_reg;
        end
        if (ctl.en[6])
        begin
            w6_reg <= w_next;
        end
        if (ctl.en[7])
        begin
            w7_reg    <= w6_reg;
            prod7_reg <= {10'd0, w6_reg} * 28'd718;
        end
        if (ctl.en[8])
        begin
            quot8_reg <= yoe_est;
            rem8_reg  <= r365_full[9:0];
        end
        if (ctl.en[9])
        begin
            yoe_reg[9] <= (rem8_reg >= 10'd365) ? quot8_reg + 9'd1 : quot8_reg;
        end
        for (int i = 10; i <= 13; i++)
        begin
            if (ctl.en[i])
            begin
                yoe_reg[i] <= yoe_reg[i-1];
            end
        end
        if (ctl.en[10])
        begin
            doy_reg[10] <= doy_full[8:0];
        end
        for (int i = 11; i <= 13; i++)
        begin
            if (ctl.en[i])
            begin
                doy_reg[i] <= doy_reg[i-1];
            end
        end
        if (ctl.en[11])
        begin
            n11_reg    <= n_next;
            prod11_reg <= {4'd0, n_next} * 15'd13;
        end
        if (ctl.en[12])
        begin
            quot12_reg <= mp_est;
            rem12_reg  <= r153_full[8:0];
        end
        if (ctl.en[13])
        begin
            mp13_reg <= (rem12_reg >= 9'd153) ? quot12_reg + 4'd1 : quot12_reg;
        end
        if (ctl.en[14])
        begin
            month14_reg <= mon;
            day14_reg   <= day_full[4:0];
            year14_reg  <= {3'd0, yoe_reg[13]} + era_year + {11'd0, (mon <= 4'd2)};
        end
    end

    assign year  = year14_reg;
    assign month = month14_reg;
    assign day   = day14_reg;

endmodule
